/* sv/scc_pkg.sv */
package scc_pkg;

	// Mode codes held in the mode register
	localparam logic [1:0] MODE_ABS = 2'd0;
	localparam logic [1:0] MODE_REL = 2'd1;
	localparam logic [1:0] MODE_DIG = 2'd2;
	// Spare code, treated as digital
	localparam logic [1:0] MODE_RSVD = 2'd3;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd7;

	// Reset values
	localparam logic [1:0] RST_MODE = MODE_REL;
	localparam logic [63:0] RST_MASKS = 64'h0;
	localparam logic [31:0] RST_STEPS = 32'h0001_0001;
	localparam logic [31:0] RST_CENTER = 32'h0078_00A0;
	localparam logic signed [15:0] RST_MIN_X = 16'sd0;
	localparam logic signed [15:0] RST_MIN_Y = 16'sd0;
	localparam logic signed [15:0] RST_MAX_X = 16'sd319;
	localparam logic signed [15:0] RST_MAX_Y = 16'sd239;
	localparam logic [15:0] RST_POS_X = 16'd160;
	localparam logic [15:0] RST_POS_Y = 16'd120;

	// Acceleration curve limits
	localparam logic [8:0] ACC_SAT_Q = 9'd192;
	localparam logic [7:0] RECIP_12 = 8'd171;
	localparam logic [4:0] ACC_MAX = 5'd16;

	typedef struct packed {
		logic [1:0] mode;
		logic [63:0] masks;
		logic [31:0] steps;
		logic [31:0] center;
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic [15:0] buttons;
		logic hold;
	} req_t;

	// Signed move of -16..16 from one stick axis
	function automatic logic signed [5:0] accel_move(input logic signed [7:0] s);
		logic [7:0] mag;
		logic [15:0] sq;
		logic [8:0] q;
		logic [16:0] prod;
		logic [4:0] m;
		logic [5:0] res;
		mag = s[7] ? 8'(-s) : 8'(s);
		sq = 16'(mag) * 16'(mag);
		q = sq[14:6];
		prod = 17'(q) * 17'(RECIP_12);
		if (q == 9'd0) begin
			m = 5'd0;
		end else if (q >= ACC_SAT_Q) begin
			m = ACC_MAX;
		end else if (prod[16:11] == 6'd0) begin
			m = 5'd1;
		end else begin
			m = prod[15:11];
		end
		res = {1'b0, m};
		return s[7] ? 6'(-res) : res;
	endfunction

	// Lower bound first, then upper bound
	function automatic logic [15:0] clamp_axis(input logic signed [15:0] v,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic [15:0] r;
		if (v < lo) begin
			r = lo;
		end else if (hi < v) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* sv/scc_next.sv */
module scc_next (
	input scc_pkg::cfg_t cfg,
	input scc_pkg::req_t req,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	output logic [15:0] next_x,
	output logic [15:0] next_y
);
	import scc_pkg::*;

	logic [15:0] cx, cy, sx2, sy2;
	logic [15:0] ax, ay;
	logic [15:0] xstep, ystep, dx, dy;
	logic [15:0] mx, my;

	// Absolute mode: centre plus twice the deflection on X, centre minus it on Y
	assign cx = cfg.center[15:0];
	assign cy = cfg.center[31:16];
	assign sx2 = {{7{req.stick_x[7]}}, req.stick_x, 1'b0};
	assign sy2 = {{7{req.stick_y[7]}}, req.stick_y, 1'b0};

	// Relative mode: accelerated step per axis
	assign ax = 16'(signed'(accel_move(req.stick_x)));
	assign ay = 16'(signed'(accel_move(req.stick_y)));

	// Digital mode: plus mask wins over minus mask
	assign xstep = cfg.steps[15:0];
	assign ystep = cfg.steps[31:16];
	always_comb begin
		dx = 16'd0;
		dy = 16'd0;
		if ((req.buttons & cfg.masks[63:48]) != 16'd0) begin
			dx = 16'(-xstep);
		end
		if ((req.buttons & cfg.masks[47:32]) != 16'd0) begin
			dx = xstep;
		end
		if ((req.buttons & cfg.masks[15:0]) != 16'd0) begin
			dy = 16'(-ystep);
		end
		if ((req.buttons & cfg.masks[31:16]) != 16'd0) begin
			dy = ystep;
		end
	end

	// Select the move, then clamp; hold keeps the position as it is
	always_comb begin
		case (cfg.mode)
			MODE_ABS: begin
				mx = 16'(cx + sx2);
				my = 16'(cy - sy2);
			end
			MODE_REL: begin
				mx = 16'(pos_x + ax);
				my = 16'(pos_y - ay);
			end
			default: begin
				mx = 16'(pos_x + dx);
				my = 16'(pos_y + dy);
			end
		endcase
		if (req.hold) begin
			next_x = pos_x;
			next_y = pos_y;
		end else begin
			next_x = clamp_axis(mx, cfg.min_x, cfg.max_x);
			next_y = clamp_axis(my, cfg.min_y, cfg.max_y);
		end
	end

endmodule

/* sv/stick_cursor_controller_core.sv */
// Stick cursor controller. Each accepted request (stick X/Y, buttons, hold)
// moves a 16-bit signed cursor in absolute, relative-accelerated or digital
// mode, clamps it to the configured rectangle and returns exactly one result
// carrying the new position. A request is registered at acceptance, the move
// and clamp are computed combinationally from it against the stored position,
// and the result is registered when the result register is free or emptying;
// with no stall a new request can be taken every cycle. The position feedback
// closes through the position register alone. Configuration registers must be
// written by the user only while no request is in flight; the block itself
// does not enforce this.
module stick_cursor_controller_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [7:0] stick_x,
	input logic signed [7:0] stick_y,
	input logic [15:0] buttons,
	input logic hold,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] cursor_x,
	output logic signed [15:0] cursor_y,
	input logic cfg_we,
	input logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [scc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scc_pkg::*;

	cfg_t cfg_q;
	req_t req_s1;
	logic valid_s1;
	logic adv_s1;
	logic [15:0] pos_x_q, pos_y_q;
	logic [15:0] next_x, next_y;
	logic out_valid_q;
	logic [15:0] cur_x_q, cur_y_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= RST_MODE;
			cfg_q.masks <= RST_MASKS;
			cfg_q.steps <= RST_STEPS;
			cfg_q.center <= RST_CENTER;
			cfg_q.min_x <= RST_MIN_X;
			cfg_q.min_y <= RST_MIN_Y;
			cfg_q.max_x <= RST_MAX_X;
			cfg_q.max_y <= RST_MAX_Y;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_MASKS: cfg_q.masks <= cfg_data;
				REG_STEPS: cfg_q.steps <= cfg_data[31:0];
				REG_CENTER: cfg_q.center <= cfg_data[31:0];
				REG_MIN_X: cfg_q.min_x <= cfg_data[15:0];
				REG_MIN_Y: cfg_q.min_y <= cfg_data[15:0];
				REG_MAX_X: cfg_q.max_x <= cfg_data[15:0];
				REG_MAX_Y: cfg_q.max_y <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage whenever the result register is free or emptying
	assign adv_s1 = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.stick_x <= stick_x;
			req_s1.stick_y <= stick_y;
			req_s1.buttons <= buttons;
			req_s1.hold <= hold;
		end
	end

	scc_next u_next (
		.cfg(cfg_q),
		.req(req_s1),
		.pos_x(pos_x_q),
		.pos_y(pos_y_q),
		.next_x(next_x),
		.next_y(next_y)
	);

	// Update the position and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= RST_POS_X;
			pos_y_q <= RST_POS_Y;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				pos_x_q <= next_x;
				pos_y_q <= next_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			cur_x_q <= next_x;
			cur_y_q <= next_y;
		end
	end

	assign out_valid = out_valid_q;
	assign cursor_x = cur_x_q;
	assign cursor_y = cur_y_q;

endmodule
